[hdl/bblru_pkg.sv]
package bblru_pkg;

  // Field widths of one request and one response
  localparam int REQ_TYPE_W  = 2;
  localparam int SLOT_W      = 4;
  localparam int HASH_W      = 32;
  localparam int BYTES_W     = 31;
  localparam int STAMP_W     = 32;
  localparam int EVICT_W     = 5;
  localparam int TOTAL_W     = 35;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;

  // Default directory depth
  localparam int NUM_SLOTS_DEF = 16;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_TRIM   = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_ENABLE = 2'd0,
    CFG_EXPORT_MODE  = 2'd1,
    CFG_BUDGET_BYTES = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_SLOT,
    S_CHECK,
    S_SCAN,
    S_EVICT,
    S_WRITE,
    S_DONE
  } state_e;

  // One directory entry as held in the entry RAM
  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [BYTES_W-1:0] bytes;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/bblru_if.sv]
// Request channel
interface bblru_req_if;
  import bblru_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [SLOT_W-1:0]     slot;
  logic [HASH_W-1:0]     key_hash;
  logic [BYTES_W-1:0]    item_size;

  modport source (output valid, req_type, slot, key_hash, item_size, input ready);
  modport sink   (input valid, req_type, slot, key_hash, item_size, output ready);
endinterface

// Response channel
interface bblru_rsp_if;
  import bblru_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic                accepted;
  logic [EVICT_W-1:0]  evicted_count;
  logic [TOTAL_W-1:0]  total_bytes;

  modport source (output valid, hit, hit_slot, accepted, evicted_count, total_bytes,
                  input ready);
  modport sink   (input valid, hit, hit_slot, accepted, evicted_count, total_bytes,
                  output ready);
endinterface

[hdl/byte_budget_lru_cache.sv]
// Byte-budget LRU cache directory. NUM_SLOTS entries (hash, size, last-use
// stamp) sit in a single-port-read entry RAM; valid marks and the running
// byte total sit in flip-flops, so reset clears the directory at once with
// no clearing pass. One request is worked on at a time and the entry RAM
// is read one entry per cycle. A lookup scans from slot 0 to the first
// match or the last slot. A remove, or an insert or remove to a slot beyond
// the directory, does no scan. A trim, and an insert that is not refused,
// evict only with enforcement, and an insert is refused when enforcement is
// on and its size exceeds the budget. Each eviction rescans every slot for
// the oldest stamp, lowest index on ties. A new request is taken while the
// previous result still waits in the output register.
module byte_budget_lru_cache #(
  parameter int NUM_SLOTS = bblru_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bblru_req_if.sink                       req,
  bblru_rsp_if.source                     rsp,
  input  logic                            cfg_we_i,
  input  logic [bblru_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bblru_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bblru_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int TOT_W = BYTES_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // Configuration registers
  logic               limit_en_q;
  logic               export_q;
  logic [BYTES_W-1:0] budget_q;
  logic               enforce;

  // Control state
  state_e               state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q;
  logic [TOT_W-1:0]     total_q;
  logic [STAMP_W-1:0]   use_cnt_q;
  logic [IDX_W-1:0]     chk_q;
  logic                 found_q;
  logic                 out_valid_q;

  // Request and working payload
  req_type_e            type_q;
  logic [IDX_W-1:0]     slot_q;
  logic [HASH_W-1:0]    key_q;
  logic [BYTES_W-1:0]   size_q;
  logic [STAMP_W-1:0]   best_stamp_q;
  logic [IDX_W-1:0]     victim_q;
  logic [BYTES_W-1:0]   victim_bytes_q;
  logic                 hit_q;
  logic [SLOT_W-1:0]    hit_slot_q;
  logic                 acc_q;
  logic [CNT_W-1:0]     evict_cnt_q;

  // Output register
  logic                 out_hit_q;
  logic [SLOT_W-1:0]    out_hit_slot_q;
  logic                 out_acc_q;
  logic [EVICT_W-1:0]   out_evict_q;
  logic [TOTAL_W-1:0]   out_total_q;

  // Entry RAM port
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  entry_t               ram_rdata;

  // Decode helpers
  logic                 in_xfer;
  logic                 out_free;
  logic                 in_range;
  logic                 is_lookup;
  logic [TOT_W:0]       need_sum;
  logic                 fits;
  logic                 scan_last;
  logic                 cur_valid;
  logic                 lk_match;
  logic                 better;

  assign enforce   = limit_en_q & ~export_q;
  assign in_xfer   = req.valid & req.ready;
  assign out_free  = ~out_valid_q | rsp.ready;
  assign in_range  = 32'(req.slot) < 32'(NUM_SLOTS);
  assign is_lookup = (type_q == REQ_LOOKUP);

  // Budget test: pending insert size plus current total against the budget
  assign need_sum  = (TOT_W + 1)'(total_q)
                   + ((type_q == REQ_INSERT) ? (TOT_W + 1)'(size_q) : '0);
  assign fits      = need_sum <= (TOT_W + 1)'(budget_q);

  // Scan compare on the entry just read
  assign scan_last = (chk_q == LAST_IDX);
  assign cur_valid = valid_q[chk_q];
  assign lk_match  = cur_valid && (ram_rdata.hash == key_q);
  assign better    = cur_valid && (!found_q || (ram_rdata.stamp < best_stamp_q));

  bblru_entry_ram #(
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (IDX_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (req_type_e'(req.req_type))
            REQ_LOOKUP: state_d = S_SCAN;
            REQ_INSERT,
            REQ_REMOVE: state_d = in_range ? S_RD_SLOT : S_DONE;
            REQ_TRIM:   state_d = enforce ? S_CHECK : S_DONE;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_RD_SLOT: begin
        if (type_q == REQ_REMOVE) begin
          state_d = S_DONE;
        end else if (enforce && (size_q > budget_q)) begin
          state_d = S_DONE;
        end else if (enforce) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_CHECK: begin
        if (!fits && (|valid_q)) begin
          state_d = S_SCAN;
        end else begin
          state_d = (type_q == REQ_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_SCAN: begin
        if (is_lookup) begin
          if (lk_match || scan_last) begin
            state_d = S_DONE;
          end
        end else if (scan_last) begin
          state_d = S_EVICT;
        end
      end
      S_EVICT: state_d = S_CHECK;
      S_WRITE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Entry RAM addressing and write-back
  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = chk_q;
    ram_wdata = '{hash: ram_rdata.hash, bytes: ram_rdata.bytes, stamp: use_cnt_q};
    case (state_q)
      S_IDLE: begin
        ram_raddr = (req_type_e'(req.req_type) == REQ_LOOKUP) ? '0 : IDX_W'(req.slot);
      end
      S_SCAN: begin
        ram_raddr = IDX_W'(chk_q + 1'b1);
        // restamp the first matching entry
        ram_we    = is_lookup && lk_match;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = '{hash: key_q, bytes: size_q, stamp: use_cnt_q};
      end
      default: ram_raddr = '0;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_en_q <= 1'b0;
      export_q   <= 1'b0;
      budget_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIMIT_ENABLE: limit_en_q <= cfg_wdata_i[0];
        CFG_EXPORT_MODE:  export_q   <= cfg_wdata_i[0];
        CFG_BUDGET_BYTES: budget_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state, valid marks and byte total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      total_q     <= '0;
      use_cnt_q   <= '0;
      chk_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_xfer && (req_type_e'(req.req_type) == REQ_LOOKUP)) begin
            use_cnt_q <= use_cnt_q + 1'b1;
            chk_q     <= '0;
          end
        end
        S_RD_SLOT: begin
          // clear the target slot before anything else
          if (valid_q[slot_q]) begin
            valid_q[slot_q] <= 1'b0;
            total_q         <= total_q - TOT_W'(ram_rdata.bytes);
          end
        end
        S_CHECK: begin
          chk_q   <= '0;
          found_q <= 1'b0;
        end
        S_SCAN: begin
          chk_q <= IDX_W'(chk_q + 1'b1);
          if (better) begin
            found_q <= 1'b1;
          end
        end
        S_EVICT: begin
          valid_q[victim_q] <= 1'b0;
          total_q           <= total_q - TOT_W'(victim_bytes_q);
        end
        S_WRITE: begin
          valid_q[slot_q] <= 1'b1;
          total_q         <= total_q + TOT_W'(size_q);
        end
        default: ;
      endcase
      // hold the response until it is taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, scan results and response payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          type_q      <= req_type_e'(req.req_type);
          slot_q      <= IDX_W'(req.slot);
          key_q       <= req.key_hash;
          size_q      <= req.item_size;
          hit_q       <= 1'b0;
          hit_slot_q  <= '0;
          acc_q       <= 1'b0;
          evict_cnt_q <= '0;
        end
      end
      S_SCAN: begin
        if (is_lookup) begin
          if (lk_match) begin
            hit_q      <= 1'b1;
            hit_slot_q <= SLOT_W'(chk_q);
          end
        end else if (better) begin
          best_stamp_q   <= ram_rdata.stamp;
          victim_q       <= chk_q;
          victim_bytes_q <= ram_rdata.bytes;
        end
      end
      S_EVICT: evict_cnt_q <= evict_cnt_q + 1'b1;
      S_WRITE: acc_q <= 1'b1;
      S_DONE: begin
        if (out_free) begin
          out_hit_q      <= hit_q;
          out_hit_slot_q <= hit_slot_q;
          out_acc_q      <= acc_q;
          out_evict_q    <= EVICT_W'(evict_cnt_q);
          out_total_q    <= TOTAL_W'(total_q);
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.hit           = out_hit_q;
  assign rsp.hit_slot      = out_hit_slot_q;
  assign rsp.accepted      = out_acc_q;
  assign rsp.evicted_count = out_evict_q;
  assign rsp.total_bytes   = out_total_q;

  // An accepted request always leaves the idle state
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("request accepted but controller stayed idle");

  // An empty directory holds no bytes
  a_empty_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q == '0) |-> (total_q == '0))
    else $error("byte total non-zero with no valid entry");

  // An eviction only removes a valid entry
  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVICT) |-> (found_q && valid_q[victim_q]))
    else $error("eviction of an invalid entry");

  // A response appears only from the completion state
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("response raised outside completion");

endmodule

[hdl/bblru_entry_ram.sv]
module bblru_entry_ram #(
  parameter int DEPTH  = bblru_pkg::NUM_SLOTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  bblru_pkg::entry_t     wdata_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output bblru_pkg::entry_t     rdata_o
);
  import bblru_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Write one entry, read one entry, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
